### hdl/source_text_tokenizer_assert.svh
// ---------------------------------------------------------------------------
// source_text_tokenizer assertion macros
// shared property forms for the tokenizer modules, clocked on clk, off in rst
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// shared types and defaults for the source text tokenizer
// ---------------------------------------------------------------------------
package stt_pkg;

  // defaults for top-level parameters
  localparam int STT_COUNTER_WIDTH = 16;
  localparam int STT_QUEUE_DEPTH   = 4;

  // bits of the packed output data word
  localparam int STT_OUT_BITS  = 65;
  localparam int STT_OUT_BYTES = (STT_OUT_BITS + 7) / 8;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0]  off;
    logic [2:0]  err;
    logic [15:0] len;
    logic [15:0] col;
    logic [15:0] line;
    logic [5:0]  kind;
  } res_t;

  // results of one input byte: none, one or two
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } pair_t;

endpackage

### hdl/stt_front.sv
// ---------------------------------------------------------------------------
// stt_front
// byte classifier and lexer state: turns each request into a result pair
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_front #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  output logic          push_valid,
  input  logic          push_ready,
  output stt_pkg::pair_t push_data
);
  import stt_pkg::*;

  localparam int CW = COUNTER_WIDTH;
  localparam int KEYWORD_BYTES = 8;

  // scanner modes
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_STRING  = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_OP      = 6'b100000
  } mode_t;

  // first half of a possible two-byte operator
  localparam logic [2:0] P_NONE  = 3'd0;
  localparam logic [2:0] P_SLASH = 3'd1;
  localparam logic [2:0] P_EQ    = 3'd2;
  localparam logic [2:0] P_BANG  = 3'd3;
  localparam logic [2:0] P_LT    = 3'd4;
  localparam logic [2:0] P_GT    = 3'd5;
  localparam logic [2:0] P_AMP   = 3'd6;
  localparam logic [2:0] P_BAR   = 3'd7;

  // token kinds
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_NUMBER   = 6'd2;
  localparam logic [5:0] K_STRING   = 6'd3;
  localparam logic [5:0] K_LET      = 6'd4;
  localparam logic [5:0] K_FN       = 6'd5;
  localparam logic [5:0] K_IF       = 6'd6;
  localparam logic [5:0] K_ELSE     = 6'd7;
  localparam logic [5:0] K_WHILE    = 6'd8;
  localparam logic [5:0] K_RETURN   = 6'd9;
  localparam logic [5:0] K_PRINT    = 6'd10;
  localparam logic [5:0] K_FOR      = 6'd11;
  localparam logic [5:0] K_BREAK    = 6'd12;
  localparam logic [5:0] K_CONTINUE = 6'd13;
  localparam logic [5:0] K_PLUS     = 6'd14;
  localparam logic [5:0] K_MINUS    = 6'd15;
  localparam logic [5:0] K_STAR     = 6'd16;
  localparam logic [5:0] K_SLASH    = 6'd17;
  localparam logic [5:0] K_PERCENT  = 6'd18;
  localparam logic [5:0] K_ASSIGN   = 6'd19;
  localparam logic [5:0] K_EQ       = 6'd20;
  localparam logic [5:0] K_NEQ      = 6'd21;
  localparam logic [5:0] K_LT       = 6'd22;
  localparam logic [5:0] K_LTE      = 6'd23;
  localparam logic [5:0] K_GT       = 6'd24;
  localparam logic [5:0] K_GTE      = 6'd25;
  localparam logic [5:0] K_ANDAND   = 6'd26;
  localparam logic [5:0] K_OROR     = 6'd27;
  localparam logic [5:0] K_BANG     = 6'd28;
  localparam logic [5:0] K_LPAREN   = 6'd29;
  localparam logic [5:0] K_RPAREN   = 6'd30;
  localparam logic [5:0] K_LBRACE   = 6'd31;
  localparam logic [5:0] K_RBRACE   = 6'd32;
  localparam logic [5:0] K_SEMI     = 6'd33;
  localparam logic [5:0] K_COMMA    = 6'd34;
  localparam logic [5:0] K_LBRACKET = 6'd35;
  localparam logic [5:0] K_RBRACKET = 6'd36;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL = 3'd1;
  localparam logic [2:0] ERR_AMP     = 3'd2;
  localparam logic [2:0] ERR_BAR     = 3'd3;
  localparam logic [2:0] ERR_UNTERM  = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  localparam logic [CW-1:0] ONE    = CW'(1);
  localparam logic [CW-1:0] KW_MAX = CW'(KEYWORD_BYTES);

  // keyword match on the buffer, first byte in the low bits
  function automatic logic [5:0] keyword_kind(input logic [63:0] kw);
    logic [5:0] k;
    unique case (kw)
      64'h0000_0000_0074_656C: k = K_LET;
      64'h0000_0000_0000_6E66: k = K_FN;
      64'h0000_0000_0000_6669: k = K_IF;
      64'h0000_0000_6573_6C65: k = K_ELSE;
      64'h0000_0065_6C69_6877: k = K_WHILE;
      64'h0000_6E72_7574_6572: k = K_RETURN;
      64'h0000_0074_6E69_7270: k = K_PRINT;
      64'h0000_0000_0072_6F66: k = K_FOR;
      64'h0000_006B_6165_7262: k = K_BREAK;
      64'h6575_6E69_746E_6F63: k = K_CONTINUE;
      default:                 k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [5:0] kind, input logic [15:0] line,
                                  input logic [15:0] col, input logic [15:0] len,
                                  input logic [2:0] err, input logic [7:0] off);
    res_t r;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.err  = err;
    r.off  = off;
    return r;
  endfunction

  // lexer state
  mode_t         mode, mode_next;
  logic [2:0]    pend, pend_next;
  logic [CW-1:0] line, line_next;
  logic [CW-1:0] col, col_next;
  logic [CW-1:0] tline, tline_next;
  logic [CW-1:0] tcol, tcol_next;
  logic [CW-1:0] tlen, tlen_next;
  logic [63:0]   kwbuf, kwbuf_next;
  logic          stopped, stopped_next;

  logic acc;
  logic is_digit, is_alpha, is_blank;

  // start-of-token decode
  mode_t      sb_mode;
  logic [2:0] sb_pend;
  logic       sb_begin, sb_len1, sb_emit, sb_fail;
  logic [5:0] sb_kind;
  res_t       sb_res;

  // pending operator flush decode
  logic       fo_emit, fo_fail;
  logic [5:0] fo_kind;
  logic [2:0] fo_err;
  logic [7:0] fo_off;
  res_t       fo_res;

  logic [5:0] word_kind;
  res_t       tok_res;
  logic       a_v, b_v, do_sb;
  res_t       a_res, b_res;

  assign acc      = in_valid && push_ready;
  assign in_ready = push_ready;

  // byte classes
  assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign is_alpha = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                    ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) || (in_byte == CH_UNDER);
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                    (in_byte == CH_LF) || (in_byte == CH_CR);

  // what a byte does when it opens a token
  always_comb begin
    sb_mode  = MODE_IDLE;
    sb_pend  = P_NONE;
    sb_begin = 1'b0;
    sb_len1  = 1'b0;
    sb_emit  = 1'b0;
    sb_fail  = 1'b0;
    sb_kind  = K_EOF;
    if (is_blank) begin
      sb_mode = MODE_IDLE;
    end else if (is_digit) begin
      sb_mode  = MODE_NUMBER;
      sb_begin = 1'b1;
      sb_len1  = 1'b1;
    end else if (is_alpha) begin
      sb_mode  = MODE_IDENT;
      sb_begin = 1'b1;
      sb_len1  = 1'b1;
    end else if (in_byte == CH_QUOTE) begin
      sb_mode  = MODE_STRING;
      sb_begin = 1'b1;
    end else begin
      case (in_byte)
        CH_PLUS:  begin sb_emit = 1'b1; sb_kind = K_PLUS;     end
        CH_MINUS: begin sb_emit = 1'b1; sb_kind = K_MINUS;    end
        CH_STAR:  begin sb_emit = 1'b1; sb_kind = K_STAR;     end
        CH_PCT:   begin sb_emit = 1'b1; sb_kind = K_PERCENT;  end
        CH_LPAR:  begin sb_emit = 1'b1; sb_kind = K_LPAREN;   end
        CH_RPAR:  begin sb_emit = 1'b1; sb_kind = K_RPAREN;   end
        CH_LBRC:  begin sb_emit = 1'b1; sb_kind = K_LBRACE;   end
        CH_RBRC:  begin sb_emit = 1'b1; sb_kind = K_RBRACE;   end
        CH_SEMI:  begin sb_emit = 1'b1; sb_kind = K_SEMI;     end
        CH_COMMA: begin sb_emit = 1'b1; sb_kind = K_COMMA;    end
        CH_LBRK:  begin sb_emit = 1'b1; sb_kind = K_LBRACKET; end
        CH_RBRK:  begin sb_emit = 1'b1; sb_kind = K_RBRACKET; end
        CH_SLASH: begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_SLASH; end
        CH_EQ:    begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_EQ;    end
        CH_BANG:  begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_BANG;  end
        CH_LT:    begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_LT;    end
        CH_GT:    begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_GT;    end
        CH_AMP:   begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_AMP;   end
        CH_BAR:   begin sb_mode = MODE_OP; sb_begin = 1'b1; sb_pend = P_BAR;   end
        default:  sb_fail = 1'b1;
      endcase
    end
    sb_res = sb_fail ? mk_res(K_EOF, 16'(line), 16'(col), 16'd0, ERR_ILLEGAL, in_byte)
                     : mk_res(sb_kind, 16'(line), 16'(col), 16'd1, ERR_NONE, 8'd0);
  end

  // pending operator without its partner: single form or error
  always_comb begin
    fo_emit = 1'b0;
    fo_fail = 1'b0;
    fo_kind = K_EOF;
    fo_err  = ERR_NONE;
    fo_off  = 8'd0;
    unique case (pend)
      P_SLASH: begin fo_emit = 1'b1; fo_kind = K_SLASH;  end
      P_EQ:    begin fo_emit = 1'b1; fo_kind = K_ASSIGN; end
      P_BANG:  begin fo_emit = 1'b1; fo_kind = K_BANG;   end
      P_LT:    begin fo_emit = 1'b1; fo_kind = K_LT;     end
      P_GT:    begin fo_emit = 1'b1; fo_kind = K_GT;     end
      P_AMP:   begin fo_fail = 1'b1; fo_err = ERR_AMP; fo_off = CH_AMP; end
      P_BAR:   begin fo_fail = 1'b1; fo_err = ERR_BAR; fo_off = CH_BAR; end
      default: fo_emit = 1'b0;
    endcase
    fo_res = fo_fail ? mk_res(K_EOF, 16'(tline), 16'(tcol), 16'd0, fo_err, fo_off)
                     : mk_res(fo_kind, 16'(tline), 16'(tcol), 16'd1, ERR_NONE, 8'd0);
  end

  // finished identifier or number
  assign word_kind = (tlen <= KW_MAX) ? keyword_kind(kwbuf) : K_IDENT;
  assign tok_res   = mk_res((mode == MODE_IDENT) ? word_kind : K_NUMBER,
                            16'(tline), 16'(tcol), 16'(tlen), ERR_NONE, 8'd0);

  // next state and results of one request
  always_comb begin
    mode_next    = mode;
    pend_next    = pend;
    line_next    = line;
    col_next     = col;
    tline_next   = tline;
    tcol_next    = tcol;
    tlen_next    = tlen;
    kwbuf_next   = kwbuf;
    stopped_next = stopped;
    a_v          = 1'b0;
    a_res        = tok_res;
    b_v          = 1'b0;
    b_res        = sb_res;
    do_sb        = 1'b0;

    if (acc && !stopped) begin
      if (in_end) begin
        // flush the open token, then end of text unless the flush stopped on an error
        unique case (mode)
          MODE_IDENT, MODE_NUMBER: begin
            a_v = 1'b1;
          end
          MODE_STRING: begin
            a_v          = 1'b1;
            a_res        = mk_res(K_EOF, 16'(tline), 16'(tcol), 16'd0, ERR_UNTERM, 8'd0);
            stopped_next = 1'b1;
          end
          MODE_OP: begin
            a_v   = fo_emit || fo_fail;
            a_res = fo_res;
            if (fo_fail) stopped_next = 1'b1;
          end
          default: a_v = 1'b0;
        endcase
        if (!stopped_next) begin
          b_v        = 1'b1;
          b_res      = mk_res(K_EOF, 16'(line), 16'(col), 16'd0, ERR_NONE, 8'd0);
          mode_next  = MODE_IDLE;
          pend_next  = P_NONE;
          line_next  = ONE;
          col_next   = ONE;
          tline_next = ONE;
          tcol_next  = ONE;
          tlen_next  = '0;
          kwbuf_next = '0;
        end
      end else begin
        unique case (mode)
          MODE_IDENT: begin
            if (is_alpha || is_digit) begin
              if (tlen < KW_MAX) kwbuf_next[8*tlen[2:0] +: 8] = in_byte;
              if (tlen != '1) tlen_next = tlen + ONE;
            end else begin
              a_v   = 1'b1;
              do_sb = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              if (tlen != '1) tlen_next = tlen + ONE;
            end else begin
              a_v   = 1'b1;
              do_sb = 1'b1;
            end
          end
          MODE_STRING: begin
            if (in_byte == CH_QUOTE) begin
              a_v       = 1'b1;
              a_res     = mk_res(K_STRING, 16'(tline), 16'(tcol), 16'(tlen), ERR_NONE, 8'd0);
              mode_next = MODE_IDLE;
            end else if (tlen != '1) begin
              tlen_next = tlen + ONE;
            end
          end
          MODE_COMMENT: begin
            if (in_byte == CH_LF) mode_next = MODE_IDLE;
          end
          MODE_OP: begin
            if (pend == P_SLASH && in_byte == CH_SLASH) begin
              mode_next = MODE_COMMENT;
              pend_next = P_NONE;
            end else if (in_byte == CH_EQ &&
                         (pend == P_EQ || pend == P_BANG || pend == P_LT || pend == P_GT)) begin
              a_v       = 1'b1;
              a_res     = mk_res((pend == P_EQ) ? K_EQ : (pend == P_BANG) ? K_NEQ :
                                 (pend == P_LT) ? K_LTE : K_GTE,
                                 16'(tline), 16'(tcol), 16'd2, ERR_NONE, 8'd0);
              mode_next = MODE_IDLE;
              pend_next = P_NONE;
            end else if ((pend == P_AMP && in_byte == CH_AMP) ||
                         (pend == P_BAR && in_byte == CH_BAR)) begin
              a_v       = 1'b1;
              a_res     = mk_res((pend == P_AMP) ? K_ANDAND : K_OROR,
                                 16'(tline), 16'(tcol), 16'd2, ERR_NONE, 8'd0);
              mode_next = MODE_IDLE;
              pend_next = P_NONE;
            end else begin
              a_v       = fo_emit || fo_fail;
              a_res     = fo_res;
              mode_next = MODE_IDLE;
              pend_next = P_NONE;
              if (fo_fail) stopped_next = 1'b1;
              else do_sb = 1'b1;
            end
          end
          default: begin
            do_sb = 1'b1;
          end
        endcase

        // the byte opens a new token
        if (do_sb) begin
          mode_next = sb_mode;
          pend_next = sb_pend;
          b_v       = sb_emit || sb_fail;
          if (sb_begin) begin
            tline_next = line;
            tcol_next  = col;
            tlen_next  = sb_len1 ? ONE : '0;
            kwbuf_next = sb_len1 && is_alpha ? {56'd0, in_byte} : 64'd0;
          end
          if (sb_fail) stopped_next = 1'b1;
        end

        // position after the byte
        if (in_byte == CH_LF) begin
          if (line != '1) line_next = line + ONE;
          col_next = ONE;
        end else if (col != '1) begin
          col_next = col + ONE;
        end
      end
    end
  end

  // pack results into the queue entry
  assign push_valid   = acc && (a_v || b_v);
  assign push_data.v0 = a_v || b_v;
  assign push_data.v1 = a_v && b_v;
  assign push_data.r0 = a_v ? a_res : b_res;
  assign push_data.r1 = b_res;

  // lexer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pend    <= P_NONE;
      line    <= ONE;
      col     <= ONE;
      tline   <= ONE;
      tcol    <= ONE;
      tlen    <= '0;
      kwbuf   <= '0;
      stopped <= 1'b0;
    end else begin
      mode    <= mode_next;
      pend    <= pend_next;
      line    <= line_next;
      col     <= col_next;
      tline   <= tline_next;
      tcol    <= tcol_next;
      tlen    <= tlen_next;
      kwbuf   <= kwbuf_next;
      stopped <= stopped_next;
    end
  end

  // checks
  `STT_ASSERT_NEXT(a_stop_sticks, stopped, stopped, "tokenizer left error stop without reset")
  `STT_ASSERT_SAME(a_stop_silent, stopped, !push_valid, "result produced after error stop")
  `STT_ASSERT_SAME(a_pend_in_op, mode != MODE_OP, pend == P_NONE, "operator pending outside op mode")

endmodule

### hdl/stt_queue.sv
// ---------------------------------------------------------------------------
// stt_queue
// short first-in first-out queue of result pairs between front and back
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  stt_pkg::pair_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output stt_pkg::pair_t pop_data
);
  import stt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  pair_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  // checks
  `STT_ASSERT_SAME(a_count_range, 1'b1, count <= FULL_CNT, "queue fill count beyond depth")

endmodule

### hdl/stt_back.sv
// ---------------------------------------------------------------------------
// stt_back
// unpacks result pairs and drives the registered output stream
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  stt_pkg::pair_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output stt_pkg::res_t  out_res,
  output logic           out_last
);
  import stt_pkg::*;

  logic take;
  logic spare_valid;
  res_t spare_res;

  // output slot free or emptied this cycle
  assign take      = !out_valid || out_ready;
  assign pop_ready = take && !spare_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (take) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else if (pop_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= pop_data.v1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (spare_valid) begin
        out_res  <= spare_res;
        out_last <= 1'b1;
      end else if (pop_valid) begin
        out_res   <= pop_data.r0;
        out_last  <= !pop_data.v1;
        spare_res <= pop_data.r1;
      end
    end
  end

  // checks
  `STT_ASSERT_SAME(a_spare_behind, spare_valid, out_valid, "second result held without first")
  `STT_ASSERT_SAME(a_pair_nonempty, pop_valid && pop_ready, pop_data.v0, "empty pair in queue")

endmodule

### hdl/source_text_tokenizer.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer
// streaming lexer: source bytes in, tokens with position and length out
// ---------------------------------------------------------------------------
//  channel  dir  tdata                          tlast / tuser
//  s_axis   in   [7:0] text_byte                tlast: end_of_input
//  m_axis   out  kind,line,col,len,err,off      tlast: last_of_run
//
//  one source byte is taken per cycle while the result queue has room
//  the output register gives one token per cycle while m_axis_tready is high;
//  two results of one byte (token ended by an operator or error, flush plus
//  eof) leave in turn, and the queue of QUEUE_DEPTH pairs absorbs such bursts
//  reset is synchronous and sets line and column to one, no clearing pass
//  after an error, bytes are still taken but give no result until reset
// ---------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int COUNTER_WIDTH = stt_pkg::STT_COUNTER_WIDTH,
  parameter int QUEUE_DEPTH   = stt_pkg::STT_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] text_byte
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [5:0] token_kind, [21:6] start_line, [37:22] start_column,
  // [53:38] lexeme_length, [56:54] error_code, [64:57] offending_byte
  output logic [8*stt_pkg::STT_OUT_BYTES-1:0] m_axis_tdata,
  output logic                                m_axis_tlast
);
  import stt_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  pair_t push_data, pop_data;
  res_t  out_res;

  // front: classify bytes and run the scanner
  stt_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue of result pairs
  stt_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: one result per output request
  stt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  // output word, padded to whole bytes
  assign m_axis_tdata = (8*STT_OUT_BYTES)'(out_res);

endmodule
